[rtl/pdv_pkg.sv]
`timescale 1ns / 1ps
package pdv_pkg;

  localparam int MAX_CLIENTS_DEF = 256;
  localparam int COORD_BITS_DEF  = 16;

  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int PORT_COORD_W = 16;
  localparam int DIST_W = 21;
  localparam int VIS_W  = 28;

  // radicand is scaled by 2^8 so the root lands in Q.4
  localparam int FRAC_SHIFT = 8;
  // quotient bits left after the fixed leading steps of 2^32 / distance
  localparam int VIS_STEPS = 28;
  // distances up to this value give a quotient of 2^28 or more
  localparam int VIS_SAT_LIMIT = 16;

  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(256);
  localparam logic [DIST_W-1:0] DIST_MAX    = '1;
  localparam logic [VIS_W-1:0]  VIS_MAX     = '1;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // start command from the front end to the sequencer
  typedef struct packed {
    logic go;
    logic calc;
    logic err;
  } pdv_job_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/pdv_ram.sv]
`timescale 1ns / 1ps
module pdv_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pdv_csu.sv]
`timescale 1ns / 1ps
module pdv_csu #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  assign ge   = (a >= b);
  assign diff = a - b;

endmodule

[rtl/pdv_core.sv]
`timescale 1ns / 1ps
module pdv_core import pdv_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AW         = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pdv_job_t                job,
  input  logic [AW-1:0]           addr_a,
  input  logic [AW-1:0]           addr_b,
  output logic                    busy,
  output logic [AW-1:0]           rd_addr,
  input  logic [2*COORD_BITS-1:0] rd_data,
  output logic                    res_valid,
  input  logic                    res_take,
  output logic [DIST_W-1:0]       res_dist,
  output logic [VIS_W-1:0]        res_vis,
  output logic                    res_status
);

  localparam int CB    = COORD_BITS;
  localparam int PW    = 2 * CB;
  localparam int SUMW  = PW + 1;
  localparam int RADW  = SUMW + FRAC_SHIFT;
  localparam int RB    = (RADW + 1) / 2;
  localparam int RADP  = 2 * RB;
  localparam int SW    = max2(RB + 3, DIST_W + 1);
  localparam int RBX   = max2(RB, DIST_W);
  localparam int STEPS = max2(RB, VIS_STEPS);
  localparam int CW    = $clog2(STEPS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_MULX = 4'd4;
  localparam logic [3:0] S_MULY = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_VCHK = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]        state;
  logic [AW-1:0]     a_q;
  logic [AW-1:0]     b_q;
  logic [CB-1:0]     xa;
  logic [CB-1:0]     ya;
  logic [CB-1:0]     dx;
  logic [CB-1:0]     dy;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     acc;
  logic [RADP-1:0]   rad;
  logic [SW-1:0]     rem;
  logic [RB-1:0]     root;
  logic [VIS_W-1:0]  quo;
  logic [CW-1:0]     cnt;
  logic [DIST_W-1:0] dist_q;
  logic              err_q;

  logic [CB-1:0]     xb;
  logic [CB-1:0]     yb;
  logic [CB-1:0]     mul_in;
  logic [PW-1:0]     mul_out;
  logic [SUMW-1:0]   sum;
  logic [SW-1:0]     sq_a;
  logic [SW-1:0]     div_a;
  logic [SW-1:0]     csu_a;
  logic [SW-1:0]     csu_b;
  logic              csu_ge;
  logic [SW-1:0]     csu_diff;
  logic [RBX-1:0]    root_x;
  logic [DIST_W-1:0] dist_v;

  assign xb = rd_data[PW-1:CB];
  assign yb = rd_data[CB-1:0];

  // one squarer, used for dx then dy
  assign mul_in  = (state == S_MULY) ? dy : dx;
  assign mul_out = mul_in * mul_in;
  assign sum     = SUMW'(acc) + SUMW'(prod);

  // shared compare-subtract: root trial or divisor
  assign sq_a  = {rem[SW-3:0], rad[RADP-1 -: 2]};
  assign div_a = {rem[SW-2:0], 1'b0};
  assign csu_a = (state == S_DIV) ? div_a : sq_a;
  assign csu_b = (state == S_DIV) ? SW'(dist_q) : SW'({root, 2'b01});

  pdv_csu #(.W(SW)) u_csu (
    .a    (csu_a),
    .b    (csu_b),
    .ge   (csu_ge),
    .diff (csu_diff)
  );

  assign root_x = RBX'(root);
  assign dist_v = (root_x > RBX'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_x);

  assign busy       = (state != S_IDLE);
  assign rd_addr    = (state == S_RDB) ? b_q : a_q;
  assign res_valid  = (state == S_DONE);
  assign res_dist   = dist_q;
  assign res_vis    = quo;
  assign res_status = err_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job.go) begin
            a_q    <= addr_a;
            b_q    <= addr_b;
            err_q  <= job.err;
            dist_q <= '0;
            quo    <= '0;
            state  <= job.calc ? S_RDA : S_DONE;
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          xa    <= xb;
          ya    <= yb;
          state <= S_DIFF;
        end
        S_DIFF: begin
          dx    <= (xa >= xb) ? xa - xb : xb - xa;
          dy    <= (ya >= yb) ? ya - yb : yb - ya;
          state <= S_MULX;
        end
        S_MULX: begin
          prod  <= mul_out;
          state <= S_MULY;
        end
        S_MULY: begin
          acc   <= prod;
          prod  <= mul_out;
          state <= S_SUM;
        end
        S_SUM: begin
          rad   <= RADP'({sum, {FRAC_SHIFT{1'b0}}});
          rem   <= '0;
          root  <= '0;
          cnt   <= CW'(RB);
          state <= S_SQRT;
        end
        S_SQRT: begin
          rad <= {rad[RADP-3:0], 2'b00};
          if (csu_ge) begin
            rem  <= csu_diff;
            root <= {root[RB-2:0], 1'b1};
          end else begin
            rem  <= sq_a;
            root <= {root[RB-2:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_VCHK;
          end
        end
        S_VCHK: begin
          dist_q <= dist_v;
          priority if (dist_v == '0) begin
            quo   <= '0;
            state <= S_DONE;
          end else if (dist_v <= DIST_W'(VIS_SAT_LIMIT)) begin
            quo   <= VIS_MAX;
            state <= S_DONE;
          end else begin
            // leading numerator bits 1,0,0,0,0 leave a remainder of 16
            rem   <= SW'(VIS_SAT_LIMIT);
            quo   <= '0;
            cnt   <= CW'(VIS_STEPS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= csu_ge ? csu_diff : div_a;
          quo <= {quo[VIS_W-2:0], csu_ge};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/pairwise_distance_visibility.sv]
// a query reads both clients, squares and sums dx and dy, then runs
//   COORD_BITS + 5 root steps plus 28 divide steps on one shared compare-subtract unit
// queries whose distance is 16 or less skip the divide
// store, out-of-range and same-client beats skip the calculation and go straight to the result;
//   one item in flight, next beat taken the cycle after the result moves to the output register
// rst (synchronous) clears the sequencer, out_valid and client_count (to 256);
//   the coordinate table is not cleared and must be written before it is queried
`timescale 1ns / 1ps
module pairwise_distance_visibility import pdv_pkg::*; #(
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CNT_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic [IDX_W-1:0]        client_index,
  input  logic [IDX_W-1:0]        other_index,
  input  logic [PORT_COORD_W-1:0] coord_x,
  input  logic [PORT_COORD_W-1:0] coord_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DIST_W-1:0]       distance,
  output logic [VIS_W-1:0]        visibility,
  output logic                    status
);

  localparam int AW = $clog2(MAX_CLIENTS);
  localparam int EW = 2 * COORD_BITS;

  logic [CNT_W-1:0]  client_count;
  logic              accept;
  logic              a_ok;
  logic              b_ok;
  logic              ram_we;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  pdv_job_t          job;
  logic              busy;
  logic              res_valid;
  logic              res_take;
  logic [DIST_W-1:0] res_dist;
  logic [VIS_W-1:0]  res_vis;
  logic              res_status;

  assign accept = in_valid && !in_stall;
  assign a_ok   = ({1'b0, client_index} < client_count) && (32'(client_index) < MAX_CLIENTS);
  assign b_ok   = ({1'b0, other_index} < client_count) && (32'(other_index) < MAX_CLIENTS);

  assign job.go   = accept;
  assign job.calc = (func == FUNC_QUERY) && a_ok && b_ok && (client_index != other_index);
  assign job.err  = (func == FUNC_STORE) ? !a_ok : !(a_ok && b_ok);

  assign ram_we    = accept && (func == FUNC_STORE) && a_ok;
  assign ram_wdata = {COORD_BITS'(coord_x), COORD_BITS'(coord_y)};

  always_ff @(posedge clk) begin
    if (rst) begin
      client_count <= COUNT_RESET;
    end else if (cfg_write) begin
      client_count <= cfg_data;
    end
  end

  pdv_ram #(.W(EW), .DEPTH(MAX_CLIENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(client_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pdv_core #(.COORD_BITS(COORD_BITS), .AW(AW)) u_core (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .addr_a     (AW'(client_index)),
    .addr_b     (AW'(other_index)),
    .busy       (busy),
    .rd_addr    (ram_raddr),
    .rd_data    (ram_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_dist   (res_dist),
    .res_vis    (res_vis),
    .res_status (res_status)
  );

  assign in_stall = busy;

  // output register: loads when empty or when its beat leaves
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      distance   <= res_dist;
      visibility <= res_vis;
      status     <= res_status;
    end
  end

endmodule

[rtl/pdv_checker.sv]
`timescale 1ns / 1ps
module pdv_checker import pdv_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DIST_W-1:0] distance,
  input logic [VIS_W-1:0]  visibility,
  input logic              status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(visibility)
      && $stable(status))
    else $error("output beat changed while stalled");

  // one item at a time: a taken beat always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_RANGE) |-> (distance == '0) && (visibility == '0))
    else $error("range error with nonzero result");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && (distance == '0) |-> (visibility == '0))
    else $error("visibility nonzero at zero distance");

  a_vis_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (distance != '0) && (distance <= DIST_W'(VIS_SAT_LIMIT))
      |-> (visibility == VIS_MAX))
    else $error("short distance did not saturate visibility");

endmodule

bind pairwise_distance_visibility pdv_checker u_pdv_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import pdv_pkg::*;

  localparam int IDLE_PCT = 36;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    bit                        func;
    bit [IDX_W-1:0]            src;
    bit [IDX_W-1:0]            dst;
    bit [PORT_COORD_W-1:0]     x;
    bit [PORT_COORD_W-1:0]     y;
    bit                        hold;
  } pdv_beat_t;

  typedef struct packed {
    bit [DIST_W-1:0] distance;
    bit [VIS_W-1:0]  visibility;
    bit              status;
  } pair_metrics_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CNT_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    func = 1'b0;
  logic [IDX_W-1:0]        client_index = '0;
  logic [IDX_W-1:0]        other_index = '0;
  logic [PORT_COORD_W-1:0] coord_x = '0;
  logic [PORT_COORD_W-1:0] coord_y = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DIST_W-1:0]       distance;
  logic [VIS_W-1:0]        visibility;
  logic                    status;

  pdv_beat_t     pending_beats[$];
  pair_metrics_t expected_metrics[$];

  // predictor copy of the table and the register
  bit [PORT_COORD_W-1:0] table_x[256];
  bit [PORT_COORD_W-1:0] table_y[256];
  bit [CNT_W-1:0]        active_count = COUNT_RESET;

  // what the stimulus side knows has been written
  bit                    gen_written[256];
  bit [PORT_COORD_W-1:0] gen_x[256];
  bit [PORT_COORD_W-1:0] gen_y[256];
  int                    gen_count = 256;

  int beats_taken = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit in_took = 1'b0;
  wire calm = (beats_taken >= 300) && (beats_taken < 400);

  pairwise_distance_visibility u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .client_index(client_index),
    .other_index(other_index),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .distance(distance),
    .visibility(visibility),
    .status(status)
  );

  always #5 clk = ~clk;

  function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
    bit [63:0] root;
    bit [63:0] probe;
    bit [63:0] rem;
    root = '0;
    rem = v;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic pair_metrics_t predict_pair_metrics(input pdv_beat_t beat);
    pair_metrics_t r;
    bit [63:0] dx;
    bit [63:0] dy;
    bit [63:0] root;
    bit [63:0] quot;
    r = '0;
    r.status = STATUS_OK;
    if (beat.func == FUNC_STORE) begin
      if (beat.src < active_count) begin
        table_x[beat.src] = beat.x;
        table_y[beat.src] = beat.y;
      end else begin
        r.status = STATUS_RANGE;
      end
    end else if (beat.src >= active_count || beat.dst >= active_count) begin
      r.status = STATUS_RANGE;
    end else if (beat.src != beat.dst) begin
      dx = (table_x[beat.src] >= table_x[beat.dst]) ? table_x[beat.src] - table_x[beat.dst]
                                                    : table_x[beat.dst] - table_x[beat.src];
      dy = (table_y[beat.src] >= table_y[beat.dst]) ? table_y[beat.src] - table_y[beat.dst]
                                                    : table_y[beat.dst] - table_y[beat.src];
      root = floor_sqrt((dx * dx + dy * dy) << FRAC_SHIFT);
      if (root > DIST_MAX) root = DIST_MAX;
      r.distance = root[DIST_W-1:0];
      if (root != 0) begin
        quot = (64'd1 << 32) / root;
        if (quot > VIS_MAX) quot = VIS_MAX;
        r.visibility = quot[VIS_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_beat(input pdv_beat_t beat);
    if (beat.func == FUNC_STORE && beat.src < gen_count) begin
      gen_written[beat.src] = 1'b1;
      gen_x[beat.src] = beat.x;
      gen_y[beat.src] = beat.y;
    end
    pending_beats.push_back(beat);
  endtask

  task automatic add_store(input int idx, input int x, input int y, input int dst);
    pdv_beat_t beat;
    beat = '0;
    beat.func = FUNC_STORE;
    beat.src = IDX_W'(idx);
    beat.dst = IDX_W'(dst);
    beat.x = PORT_COORD_W'(x);
    beat.y = PORT_COORD_W'(y);
    add_beat(beat);
  endtask

  task automatic add_query(input int src, input int dst);
    pdv_beat_t beat;
    beat = '0;
    beat.func = FUNC_QUERY;
    beat.src = IDX_W'(src);
    beat.dst = IDX_W'(dst);
    beat.x = PORT_COORD_W'($urandom_range(65535, 0));
    beat.y = PORT_COORD_W'($urandom_range(65535, 0));
    add_beat(beat);
  endtask

  task automatic add_random_beat(input bit hold);
    pdv_beat_t beat;
    int live[$];
    int pick;
    int roll;
    for (int i = 0; i < gen_count; i++) if (gen_written[IDX_W'(i)]) live.push_back(i);
    beat = '0;
    beat.hold = hold;
    beat.dst = IDX_W'($urandom_range(255, 0));
    beat.x = PORT_COORD_W'($urandom_range(65535, 0));
    beat.y = PORT_COORD_W'($urandom_range(65535, 0));
    if (live.size() == 0 || $urandom_range(99, 0) < 40) begin
      beat.func = FUNC_STORE;
      if (gen_count < 256 && $urandom_range(99, 0) < 15)
        beat.src = IDX_W'($urandom_range(255, gen_count));
      else
        beat.src = IDX_W'($urandom_range(gen_count - 1, 0));
      // cluster near a known client to hit tiny distances and visibility saturation
      if (live.size() != 0 && $urandom_range(99, 0) < 30) begin
        pick = live[$urandom_range(live.size() - 1, 0)];
        beat.x = PORT_COORD_W'(gen_x[IDX_W'(pick)] + $urandom_range(2, 0));
        beat.y = PORT_COORD_W'(gen_y[IDX_W'(pick)] + $urandom_range(2, 0));
      end
    end else begin
      beat.func = FUNC_QUERY;
      beat.src = IDX_W'(live[$urandom_range(live.size() - 1, 0)]);
      beat.dst = IDX_W'(live[$urandom_range(live.size() - 1, 0)]);
      roll = $urandom_range(99, 0);
      if (gen_count < 256 && roll < 12) begin
        if ($urandom_range(1, 0)) beat.src = IDX_W'($urandom_range(255, gen_count));
        else beat.dst = IDX_W'($urandom_range(255, gen_count));
      end else if (roll < 20) begin
        beat.dst = beat.src;
      end
    end
    add_beat(beat);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_metrics.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_client_count(input int value);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= CNT_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    gen_count = value;
  endtask

  // driver
  always @(negedge clk) begin : drive_beats
    pdv_beat_t nb;
    bit go;
    if (!rst && (!in_valid || in_took)) begin
      go = (pending_beats.size() != 0) && (calm || $urandom_range(99, 0) >= IDLE_PCT);
      // a held beat waits until every result has drained
      if (go && pending_beats[0].hold && expected_metrics.size() != 0) go = 1'b0;
      if (go) begin
        nb = pending_beats.pop_front();
        in_valid <= 1'b1;
        func <= nb.func;
        client_index <= nb.src;
        other_index <= nb.dst;
        coord_x <= nb.x;
        coord_y <= nb.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && !calm && ($urandom_range(99, 0) < IDLE_PCT);
  end

  // monitor and scoreboard
  always @(posedge clk) begin : watch_beats
    pdv_beat_t beat;
    pair_metrics_t want;
    if (rst) begin
      active_count = COUNT_RESET;
      in_took = 1'b0;
    end else begin
      if (cfg_write) active_count = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_metrics.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_metrics.pop_front();
          if (distance !== want.distance)
            report_mismatch($sformatf("distance got %0h want %0h", distance, want.distance));
          if (visibility !== want.visibility)
            report_mismatch($sformatf("visibility got %0h want %0h", visibility,
                                      want.visibility));
          if (status !== want.status)
            report_mismatch($sformatf("status got %0b want %0b", status, want.status));
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        beat = '0;
        beat.func = func;
        beat.src = client_index;
        beat.dst = other_index;
        beat.x = coord_x;
        beat.y = coord_y;
        expected_metrics.push_back(predict_pair_metrics(beat));
        beats_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // extremes and special cases at the reset count of 256
    add_store(0, 16'h0000, 16'h0000, 8'hFF);
    add_store(255, 16'hFFFF, 16'hFFFF, 8'h00);
    add_store(1, 16'h0000, 16'hFFFF, 8'h5A);
    add_store(2, 16'hFFFF, 16'h0000, 8'hA5);
    add_store(3, 16'h0000, 16'h0000, 8'h00);
    add_store(4, 16'h0001, 16'h0000, 8'h00);
    add_store(5, 16'h0010, 16'h0000, 8'h00);
    add_store(6, 16'hAAAA, 16'h5555, 8'h00);
    add_store(7, 16'h5555, 16'hAAAA, 8'h00);
    add_query(0, 255);
    add_query(255, 0);
    add_query(0, 0);
    add_query(0, 3);
    add_query(0, 4);
    add_query(4, 0);
    add_query(0, 5);
    add_query(1, 2);
    add_query(6, 7);
    add_query(255, 255);
    add_query(0, 1);
    for (int i = 0; i < 180; i++) add_random_beat(i == 90);

    // a single client: only client 0 is in range
    set_client_count(1);
    for (int i = 0; i < 50; i++) add_random_beat(1'b0);

    set_client_count($urandom_range(254, 2));
    for (int i = 0; i < 150; i++) add_random_beat(i == 40);

    set_client_count(255);
    add_query(255, 0);
    add_store(255, 16'h1234, 16'h4321, 8'h00);
    for (int i = 0; i < 100; i++) add_random_beat(1'b0);

    set_client_count(256);
    for (int i = 0; i < 100; i++) add_random_beat(1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pdv_pkg.sv
rtl/pdv_ram.sv
rtl/pdv_csu.sv
rtl/pdv_core.sv
rtl/pairwise_distance_visibility.sv
rtl/pdv_checker.sv
tb/tb_top.sv
